// ===== src/sgur_pkg.sv =====
// ----------------------------------------------------------------------------
// sgur_pkg
// Shared types and constants for the star grid reorder block.
// ----------------------------------------------------------------------------
package sgur_pkg;

   localparam int MAX_STARS_DEF  = 64;
   localparam int COORD_BITS_DEF = 24;

   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DAT_BITS = 7;

   localparam logic [CSR_IDX_BITS-1:0] REG_NUM_BOXES  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_KEEP_LIMIT = 4'd1;

   localparam logic [6:0] NUM_BOXES_RST  = 7'd10;
   localparam logic [6:0] KEEP_LIMIT_RST = 7'd64;

   typedef struct packed {
      logic [23:0] star_x;
      logic [23:0] star_y;
      logic [31:0] star_payload;
      logic        load_last;
   } req_type;

   typedef struct packed {
      logic [23:0] out_x;
      logic [23:0] out_y;
      logic [31:0] out_payload;
      logic [5:0]  source_slot;
      logic        status;
      logic        emit_last;
   } rsp_type;

endpackage

// ===== src/sgur_div.sv =====
// ----------------------------------------------------------------------------
// sgur_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgur_div import sgur_pkg::*; #(
   parameter int NW = COORD_BITS_DEF + 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);

   localparam int CNW = $clog2(NW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [NW-1:0] den_ff, den_in;
   logic [NW:0]   shifted;

   assign shifted = {rem_ff, quo_ff[NW-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNW'(NW);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = NW'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/star_grid_uniform_reorder.sv =====
// ----------------------------------------------------------------------------
// star_grid_uniform_reorder
// Collects a star set, bins it on a grid and gives it out rank by rank.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: a star request is taken when start is high and busy
//    is low. Loading takes one star per cycle while busy stays low.
//  - The star flagged load_last (or the MAX_STARS-th star) closes the set;
//    busy then rises and drops again in the cycle in which the last result
//    is on rsp_item.
//  - Results come out on rsp_item, each for one cycle with rsp_valid high.
//    The receiver cannot stall; every strobe is a delivered result.
//  - Processing after the closing star: a grid sizing pass (one division,
//    a square root at one bit pair per cycle, one more division), then per
//    star two divisions on the shared divider plus a rank walk over every
//    earlier star, then an emit sweep over every star per rank level.
//  - Zero extent: stars come out in load order with status 1, after only
//    the emit sweep.
//  - CSR channel: always ready; write only while idle.
//  - Reset: synchronous; empties the set and restores num_boxes=10 and
//    keep_limit=64. Star memories hold no reset value.
// ----------------------------------------------------------------------------
module star_grid_uniform_reorder import sgur_pkg::*; #(
   parameter int MAX_STARS  = MAX_STARS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_item,
   output logic                    rsp_valid,
   output rsp_type                 rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_data
);

   localparam int CB = COORD_BITS;
   localparam int IW = $clog2(MAX_STARS);
   localparam int CW = $clog2(MAX_STARS + 1);
   localparam int NW = CB + 16;           // divider width
   localparam int SW = ((CB + 10) / 2) * 2; // square root width, even

   typedef enum logic [15:0] {
      S_LOAD = 16'h0001,
      S_PREP = 16'h0002,
      S_Q4   = 16'h0004,
      S_SQRT = 16'h0008,
      S_NBY0 = 16'h0010,
      S_NBY  = 16'h0020,
      S_BRD  = 16'h0040,
      S_BMUL = 16'h0080,
      S_BDX  = 16'h0100,
      S_BWX  = 16'h0200,
      S_BDY  = 16'h0400,
      S_BWY  = 16'h0800,
      S_BCEL = 16'h1000,
      S_RRD  = 16'h2000,
      S_RCMP = 16'h4000,
      S_ECHK = 16'h8000
   } state_type;

   // emit read cycle shares the encoding space via a flag
   state_type       state_ff, state_in;
   logic            erd_ff, erd_in;   // emit sweep in its address cycle

   // config
   logic [6:0]      nb_ff, nb_in;
   logic [6:0]      keep_ff, keep_in;

   // set tracking
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CB-1:0]   minx_ff, minx_in, maxx_ff, maxx_in;
   logic [CB-1:0]   miny_ff, miny_in, maxy_ff, maxy_in;

   // memories
   logic [CB-1:0]   x_mem [MAX_STARS];
   logic [CB-1:0]   y_mem [MAX_STARS];
   logic [31:0]     p_mem [MAX_STARS];
   logic [31:0]     cell_mem [MAX_STARS];
   logic [IW-1:0]   rank_mem [MAX_STARS];
   logic [CB-1:0]   x_rd_ff, y_rd_ff;
   logic [31:0]     p_rd_ff, cell_rd_ff;
   logic [IW-1:0]   rank_rd_ff;

   // sequencer datapath
   logic            zero_ff, zero_in;
   logic [SW-1:0]   v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [15:0]     nbx_ff, nbx_in, nby_ff, nby_in;
   logic [15:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [NW-1:0]   prodx_ff, prodx_in, prody_ff, prody_in;
   logic [31:0]     cell_ff, cell_in;
   logic [IW-1:0]   idx_ff, idx_in, j_ff, j_in, rk_ff, rk_in;
   logic [IW-1:0]   maxrank_ff, maxrank_in, lvl_ff, lvl_in;
   logic [6:0]      k_ff, k_in;

   // pending result and output
   logic            pend_ff, pend_in;
   logic [CB-1:0]   pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [31:0]     pend_p_ff, pend_p_in;
   logic [IW-1:0]   pend_s_ff, pend_s_in;
   logic            rv_ff, rv_in;
   rsp_type         ro_ff, ro_in;

   // divider
   logic            div_start, div_done;
   logic [NW-1:0]   div_num, div_den, div_quo;

   // load write
   logic            ld_take;
   logic [CB-1:0]   xin, yin;
   logic [CB-1:0]   wid, hgt;
   logic [SW:0]     sq_try;
   logic [SW-1:0]   sq_half;
   logic [IW-1:0]   lvl_cmp;

   assign ld_take = start && !busy;
   assign xin = CB'(req_item.star_x);
   assign yin = CB'(req_item.star_y);
   assign wid = maxx_ff - minx_ff;
   assign hgt = maxy_ff - miny_ff;
   assign sq_try  = {1'b0, r_ff} + {1'b0, bit_ff};
   assign sq_half = SW'(({1'b0, r_ff} + 1'b1) >> 1);
   assign lvl_cmp = zero_ff ? '0 : rank_rd_ff;

   sgur_div #(.NW(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         S_PREP: begin
            div_start = !erd_ff && (wid != '0) && (hgt != '0);
            div_num   = NW'({NW'(nb_ff) * NW'(wid), 2'b00});
            div_den   = NW'(hgt);
         end
         S_NBY0: begin
            div_start = 1'b1;
            div_num   = NW'({nb_ff, 1'b0}) + NW'(nbx_ff) - NW'(1);
            div_den   = NW'({nbx_ff, 1'b0});
         end
         S_BDX: begin
            div_start = 1'b1;
            div_num   = prodx_ff;
            div_den   = NW'(wid);
         end
         S_BDY: begin
            div_start = 1'b1;
            div_num   = prody_ff;
            div_den   = NW'(hgt);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      erd_in     = 1'b0;
      nb_in      = nb_ff;
      keep_in    = keep_ff;
      cnt_in     = cnt_ff;
      minx_in    = minx_ff;
      maxx_in    = maxx_ff;
      miny_in    = miny_ff;
      maxy_in    = maxy_ff;
      zero_in    = zero_ff;
      v_in       = v_ff;
      r_in       = r_ff;
      bit_in     = bit_ff;
      nbx_in     = nbx_ff;
      nby_in     = nby_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      prodx_in   = prodx_ff;
      prody_in   = prody_ff;
      cell_in    = cell_ff;
      idx_in     = idx_ff;
      j_in       = j_ff;
      rk_in      = rk_ff;
      maxrank_in = maxrank_ff;
      lvl_in     = lvl_ff;
      k_in       = k_ff;
      pend_in    = pend_ff;
      pend_x_in  = pend_x_ff;
      pend_y_in  = pend_y_ff;
      pend_p_in  = pend_p_ff;
      pend_s_in  = pend_s_ff;
      rv_in      = 1'b0;
      ro_in      = ro_ff;

      if (csr_valid) begin
         if (csr_index == REG_NUM_BOXES) begin
            nb_in = csr_data;
         end else if (csr_index == REG_KEEP_LIMIT) begin
            keep_in = csr_data;
         end
      end

      if (erd_ff) begin
         // emit address cycle: read data lands next cycle
         state_in = S_ECHK;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (ld_take) begin
                  if (cnt_ff == '0) begin
                     minx_in = xin;
                     maxx_in = xin;
                     miny_in = yin;
                     maxy_in = yin;
                  end else begin
                     if (xin < minx_ff) minx_in = xin;
                     if (xin > maxx_ff) maxx_in = xin;
                     if (yin < miny_ff) miny_in = yin;
                     if (yin > maxy_ff) maxy_in = yin;
                  end
                  cnt_in = cnt_ff + 1'b1;
                  if (req_item.load_last || (cnt_ff == CW'(MAX_STARS - 1))) begin
                     state_in = S_PREP;
                  end
               end
            end
            S_PREP: begin
               idx_in     = '0;
               lvl_in     = '0;
               k_in       = '0;
               pend_in    = 1'b0;
               maxrank_in = '0;
               if ((wid == '0) || (hgt == '0)) begin
                  zero_in = 1'b1;
                  erd_in  = 1'b1;
               end else begin
                  zero_in  = 1'b0;
                  state_in = S_Q4;
               end
            end
            S_Q4: begin
               if (div_done) begin
                  v_in     = SW'(div_quo);
                  r_in     = '0;
                  bit_in   = SW'(1) << (SW - 2);
                  state_in = S_SQRT;
               end
            end
            S_SQRT: begin
               if (bit_ff == '0) begin
                  if (sq_half == '0) begin
                     nbx_in = 16'd1;
                  end else if (sq_half > SW'(16'hFFFF)) begin
                     nbx_in = 16'hFFFF;
                  end else begin
                     nbx_in = sq_half[15:0];
                  end
                  state_in = S_NBY0;
               end else begin
                  if ({1'b0, v_ff} >= sq_try) begin
                     v_in = SW'({1'b0, v_ff} - sq_try);
                     r_in = (r_ff >> 1) + bit_ff;
                  end else begin
                     r_in = r_ff >> 1;
                  end
                  bit_in = bit_ff >> 2;
               end
            end
            S_NBY0: begin
               state_in = S_NBY;
            end
            S_NBY: begin
               if (div_done) begin
                  nby_in   = (div_quo == '0) ? 16'd1 : div_quo[15:0];
                  state_in = S_BRD;
               end
            end
            S_BRD: begin
               state_in = S_BMUL;
            end
            S_BMUL: begin
               prodx_in = NW'(x_rd_ff - minx_ff) * NW'(nbx_ff);
               prody_in = NW'(y_rd_ff - miny_ff) * NW'(nby_ff);
               state_in = S_BDX;
            end
            S_BDX: begin
               state_in = S_BWX;
            end
            S_BWX: begin
               if (div_done) begin
                  cx_in = (div_quo > NW'(nbx_ff - 1'b1)) ? nbx_ff - 1'b1 : div_quo[15:0];
                  state_in = S_BDY;
               end
            end
            S_BDY: begin
               state_in = S_BWY;
            end
            S_BWY: begin
               if (div_done) begin
                  cy_in = (div_quo > NW'(nby_ff - 1'b1)) ? nby_ff - 1'b1 : div_quo[15:0];
                  state_in = S_BCEL;
               end
            end
            S_BCEL: begin
               cell_in  = 32'(cy_ff) * 32'(nbx_ff) + 32'(cx_ff);
               j_in     = '0;
               rk_in    = '0;
               state_in = S_RRD;
            end
            S_RRD: begin
               if (j_ff == idx_ff) begin
                  if (rk_ff > maxrank_ff) maxrank_in = rk_ff;
                  if (CW'(idx_ff) == cnt_ff - 1'b1) begin
                     idx_in = '0;
                     erd_in = 1'b1;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_BRD;
                  end
               end else begin
                  state_in = S_RCMP;
               end
            end
            S_RCMP: begin
               if (cell_rd_ff == cell_ff) rk_in = rk_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = S_RRD;
            end
            S_ECHK: begin
               if ((lvl_cmp == lvl_ff) && (k_ff < keep_ff)) begin
                  if (pend_ff) begin
                     rv_in = 1'b1;
                     ro_in = '{out_x: 24'(pend_x_ff), out_y: 24'(pend_y_ff),
                               out_payload: pend_p_ff, source_slot: 6'(pend_s_ff),
                               status: zero_ff, emit_last: 1'b0};
                  end
                  pend_in   = 1'b1;
                  pend_x_in = x_rd_ff;
                  pend_y_in = y_rd_ff;
                  pend_p_in = p_rd_ff;
                  pend_s_in = idx_ff;
                  k_in      = k_ff + 1'b1;
               end
               if (CW'(idx_ff) == cnt_ff - 1'b1) begin
                  idx_in = '0;
                  lvl_in = lvl_ff + 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               if (((lvl_cmp == lvl_ff) && (k_ff + 1'b1 >= keep_ff))
                   || (keep_ff == '0)
                   || ((CW'(idx_ff) == cnt_ff - 1'b1) && (lvl_ff == maxrank_ff))) begin
                  // set done: flush the held result as the last one
                  if (pend_in) begin
                     rv_in = 1'b1;
                     ro_in = '{out_x: 24'(pend_x_in), out_y: 24'(pend_y_in),
                               out_payload: pend_p_in, source_slot: 6'(pend_s_in),
                               status: zero_ff, emit_last: 1'b1};
                  end
                  pend_in  = 1'b0;
                  cnt_in   = '0;
                  minx_in  = '0;
                  maxx_in  = '0;
                  miny_in  = '0;
                  maxy_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  erd_in = 1'b1;
               end
            end
            default: begin
               state_in = S_LOAD;
            end
         endcase
      end
   end

   // At the end of a set a held result and a new match can meet in one
   // cycle: the held one goes out first, the new one (flagged last) goes out
   // in the cycle after it. busy stays high while the held one is out.
   logic            flush_ff, flush_in;
   rsp_type         flush_item_ff, flush_item_in;

   always_comb begin
      flush_in      = 1'b0;
      flush_item_in = flush_item_ff;
      if (!erd_ff && (state_ff == S_ECHK) && (state_in == S_LOAD)
          && (lvl_cmp == lvl_ff) && (k_ff < keep_ff) && pend_ff) begin
         flush_in      = 1'b1;
         flush_item_in = '{out_x: 24'(x_rd_ff), out_y: 24'(y_rd_ff),
                           out_payload: p_rd_ff, source_slot: 6'(idx_ff),
                           status: zero_ff, emit_last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         erd_ff     <= 1'b0;
         nb_ff      <= NUM_BOXES_RST;
         keep_ff    <= KEEP_LIMIT_RST;
         cnt_ff     <= '0;
         minx_ff    <= '0;
         maxx_ff    <= '0;
         miny_ff    <= '0;
         maxy_ff    <= '0;
         pend_ff    <= 1'b0;
         rv_ff      <= 1'b0;
         flush_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         erd_ff     <= erd_in;
         nb_ff      <= nb_in;
         keep_ff    <= keep_in;
         cnt_ff     <= cnt_in;
         minx_ff    <= minx_in;
         maxx_ff    <= maxx_in;
         miny_ff    <= miny_in;
         maxy_ff    <= maxy_in;
         pend_ff    <= pend_in;
         rv_ff      <= rv_in || flush_ff;
         flush_ff   <= flush_in;
      end
      zero_ff    <= zero_in;
      v_ff       <= v_in;
      r_ff       <= r_in;
      bit_ff     <= bit_in;
      nbx_ff     <= nbx_in;
      nby_ff     <= nby_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      prodx_ff   <= prodx_in;
      prody_ff   <= prody_in;
      cell_ff    <= cell_in;
      idx_ff     <= idx_in;
      j_ff       <= j_in;
      rk_ff      <= rk_in;
      maxrank_ff <= maxrank_in;
      lvl_ff     <= lvl_in;
      k_ff       <= k_in;
      pend_x_ff  <= pend_x_in;
      pend_y_ff  <= pend_y_in;
      pend_p_ff  <= pend_p_in;
      pend_s_ff  <= pend_s_in;
      flush_item_ff <= flush_item_in;
      if (flush_in) begin
         ro_ff <= '{out_x: 24'(pend_x_ff), out_y: 24'(pend_y_ff),
                    out_payload: pend_p_ff, source_slot: 6'(pend_s_ff),
                    status: zero_ff, emit_last: 1'b0};
      end else if (flush_ff) begin
         ro_ff <= flush_item_ff;
      end else begin
         ro_ff <= ro_in;
      end
   end

   // memories: one write port each, registered reads
   always_ff @(posedge clock) begin
      if (ld_take) begin
         x_mem[cnt_ff[IW-1:0]] <= xin;
         y_mem[cnt_ff[IW-1:0]] <= yin;
         p_mem[cnt_ff[IW-1:0]] <= req_item.star_payload;
      end
      if (!erd_ff && (state_ff == S_RRD) && (j_ff == idx_ff)) begin
         cell_mem[idx_ff] <= cell_ff;
         rank_mem[idx_ff] <= rk_ff;
      end
      x_rd_ff    <= x_mem[idx_ff];
      y_rd_ff    <= y_mem[idx_ff];
      p_rd_ff    <= p_mem[idx_ff];
      rank_rd_ff <= rank_mem[idx_ff];
      cell_rd_ff <= cell_mem[j_ff];
   end

   // flush cycle: state is already back in load, busy holds requests off

   assign busy      = (state_ff != S_LOAD) || erd_ff || flush_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_item  = ro_ff;

   // closing star always makes the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.load_last) |=> busy)
      else $error("set close did not raise busy");

   // loaded count stays within the store
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_STARS))
      else $error("loaded count beyond store depth");

   // every result follows at least one counted emit
   assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (k_ff != '0))
      else $error("result without an emit count");

   // final result is not directly followed by another result
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ro_ff.emit_last) |=> !rv_ff)
      else $error("result after final result");

endmodule
